// ===== src/assert_macros.svh =====
// shared assertion helpers for the box sum core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define IIBS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IIBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/iibs_pkg.sv =====
`default_nettype none

package iibs_pkg;

	localparam int SUM_W       = 28;
	localparam int ROW_SUM_W   = 18;
	localparam int ROW_W       = 10;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = 11;
	localparam int WIN_ROWS_W  = 7;
	localparam int OUT_TDATA_W = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_ROWS  = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_COLS  = 8'd3;

	localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RESET  = 11'd1024;
	localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RESET = 11'd1024;
	localparam logic [WIN_ROWS_W-1:0] WINDOW_ROWS_RESET  = 7'd1;
	localparam logic [CFG_DATA_W-1:0] WINDOW_COLS_RESET  = 11'd1;

	// last row the counter can hold
	localparam logic [ROW_W-1:0] ROW_LAST = 10'd1023;

	typedef struct packed {
		logic a_zero;     // row above is outside the frame
		logic top_zero;   // row above the box is outside the frame
		logic left_zero;  // column left of the box is outside the frame
		logic box_valid;
		logic frame_end;
	} iibs_flags_t;

endpackage

`default_nettype wire

// ===== src/integral_image_box_sum_core.sv =====
// a pixel word taken passes the queue, stage 2, stage 3 and the output register
// throughput: one pixel word per cycle with m_tready high; two line store copies,
//   each with one write and two read ports, give the four table reads per pixel
// reset: arst_n clears counters, running row sum, queue and pipeline valids, and
//   loads the default configuration; the line store is not cleared and needs no pass
`default_nettype none

module integral_image_box_sum_core
	import iibs_pkg::*;
#(
	parameter int MAX_WIDTH       = 1024,
	parameter int MAX_WINDOW_ROWS = 64,
	parameter int PIXEL_BITS      = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [CFG_INDEX_W-1:0]               cfg_index,
	input  logic [CFG_DATA_W-1:0]                cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((PIXEL_BITS + 7) / 8) * 8-1:0] s_tdata,  // pixel
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [OUT_TDATA_W-1:0]               m_tdata,   // box_sum
	output logic                                 m_tuser,   // box_valid
	output logic                                 m_tlast    // frame_end
);

	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int LINES       = MAX_WINDOW_ROWS + 1;
	localparam int SLOT_W      = $clog2(LINES);
	localparam int ADDR_W      = SLOT_W + COL_W;
	localparam int MEM_DEPTH   = LINES * (2 ** COL_W);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int Q_W         = $bits(iibs_flags_t) + ROW_SUM_W + 5 * ADDR_W;

	iibs_flags_t          f_flags, h_flags;
	logic [ROW_SUM_W-1:0] f_row_sum, h_row_sum;
	logic [ADDR_W-1:0]    f_addr_w, f_addr_a, f_addr_b, f_addr_c, f_addr_d;
	logic [ADDR_W-1:0]    h_addr_w, h_addr_a, h_addr_b, h_addr_c, h_addr_d;
	logic [Q_W-1:0]       q_in, q_out;
	logic                 q_push, q_full, q_pop, q_valid;

	iibs_front #(
		.MAX_WIDTH       (MAX_WIDTH),
		.MAX_WINDOW_ROWS (MAX_WINDOW_ROWS),
		.PIXEL_BITS      (PIXEL_BITS),
		.COL_W           (COL_W),
		.SLOT_W          (SLOT_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (s_tvalid),
		.pixel_ready  (s_tready),
		.pixel        (s_tdata[PIXEL_BITS-1:0]),
		.q_full       (q_full),
		.q_push       (q_push),
		.item_flags   (f_flags),
		.item_row_sum (f_row_sum),
		.addr_w       (f_addr_w),
		.addr_a       (f_addr_a),
		.addr_b       (f_addr_b),
		.addr_c       (f_addr_c),
		.addr_d       (f_addr_d)
	);

	assign q_in = {f_flags, f_row_sum, f_addr_w, f_addr_a, f_addr_b, f_addr_c, f_addr_d};

	iibs_queue #(
		.DATA_W (Q_W),
		.DEPTH  (QUEUE_DEPTH),
		.PTR_W  (QPTR_W)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_data  (q_out)
	);

	assign {h_flags, h_row_sum, h_addr_w, h_addr_a, h_addr_b, h_addr_c, h_addr_d} = q_out;

	iibs_back #(
		.ADDR_W    (ADDR_W),
		.MEM_DEPTH (MEM_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.q_flags   (h_flags),
		.q_row_sum (h_row_sum),
		.q_addr_w  (h_addr_w),
		.q_addr_a  (h_addr_a),
		.q_addr_b  (h_addr_b),
		.q_addr_c  (h_addr_c),
		.q_addr_d  (h_addr_d),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire

// ===== src/iibs_front.sv =====
`default_nettype none

module iibs_front
	import iibs_pkg::*;
#(
	parameter int MAX_WIDTH       = 1024,
	parameter int MAX_WINDOW_ROWS = 64,
	parameter int PIXEL_BITS      = 8,
	parameter int COL_W           = 10,
	parameter int SLOT_W          = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  logic                       pixel_valid,
	output logic                       pixel_ready,
	input  logic [PIXEL_BITS-1:0]      pixel,
	input  logic                       q_full,
	output logic                       q_push,
	output iibs_flags_t                item_flags,
	output logic [ROW_SUM_W-1:0]       item_row_sum,
	output logic [SLOT_W+COL_W-1:0]    addr_w,
	output logic [SLOT_W+COL_W-1:0]    addr_a,
	output logic [SLOT_W+COL_W-1:0]    addr_b,
	output logic [SLOT_W+COL_W-1:0]    addr_c,
	output logic [SLOT_W+COL_W-1:0]    addr_d
);

	localparam int LINES  = MAX_WINDOW_ROWS + 1;
	localparam int CMP_W  = (COL_W + 1 > CFG_DATA_W) ? COL_W + 1 : CFG_DATA_W;
	localparam int RCMP_W = ((ROW_W > SLOT_W) ? ROW_W : SLOT_W) + 1;

	logic [CFG_DATA_W-1:0] img_w_q;
	logic [CFG_DATA_W-1:0] img_h_q;
	logic [WIN_ROWS_W-1:0] win_rows_q;
	logic [CFG_DATA_W-1:0] win_cols_q;

	logic [COL_W-1:0]     col_q;
	logic [ROW_W-1:0]     row_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [ROW_SUM_W-1:0] row_sum_q;

	logic [SLOT_W-1:0]     wr_eff;
	logic [CFG_DATA_W-1:0] wc_eff;
	logic [CMP_W-1:0]      col_x, col_inc, wc_x, col_diff;
	logic [RCMP_W-1:0]     row_x, row_inc, wr_x;
	logic [SLOT_W:0]       slot_diff;
	logic [SLOT_W-1:0]     slot_prev, slot_top;
	logic [COL_W-1:0]      col_left;
	logic                  last_col, last_row;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q    <= IMAGE_WIDTH_RESET;
			img_h_q    <= IMAGE_HEIGHT_RESET;
			win_rows_q <= WINDOW_ROWS_RESET;
			win_cols_q <= WINDOW_COLS_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  img_w_q    <= cfg_data;
				REG_IMAGE_HEIGHT: img_h_q    <= cfg_data;
				REG_WINDOW_ROWS:  win_rows_q <= cfg_data[WIN_ROWS_W-1:0];
				REG_WINDOW_COLS:  win_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (win_rows_q == '0) begin
			wr_eff = SLOT_W'(1);
		end else if (int'(win_rows_q) > MAX_WINDOW_ROWS) begin
			wr_eff = SLOT_W'(MAX_WINDOW_ROWS);
		end else begin
			wr_eff = SLOT_W'(win_rows_q);
		end
	end

	assign wc_eff = (win_cols_q == '0) ? CFG_DATA_W'(1) : win_cols_q;

	assign col_x    = CMP_W'(col_q);
	assign col_inc  = col_x + CMP_W'(1);
	assign wc_x     = CMP_W'(wc_eff);
	assign col_diff = col_x - wc_x;
	assign col_left = col_diff[COL_W-1:0];

	assign row_x   = RCMP_W'(row_q);
	assign row_inc = row_x + RCMP_W'(1);
	assign wr_x    = RCMP_W'(wr_eff);

	// width or height past the limit ends row or frame at the limit anyway
	assign last_col = (col_inc >= CMP_W'(img_w_q)) || (col_q == COL_W'(MAX_WIDTH - 1));
	assign last_row = (row_inc >= RCMP_W'(img_h_q)) || (row_q == ROW_LAST);

	assign slot_prev = (slot_q == '0) ? SLOT_W'(LINES - 1) : slot_q - SLOT_W'(1);
	assign slot_diff = {1'b0, slot_q} - {1'b0, wr_eff};
	// wrap round the circular line store
	assign slot_top  = slot_diff[SLOT_W] ? slot_diff[SLOT_W-1:0] + SLOT_W'(LINES)
		: slot_diff[SLOT_W-1:0];

	assign item_flags.a_zero    = (row_q == '0);
	assign item_flags.top_zero  = (row_x < wr_x);
	assign item_flags.left_zero = (col_x < wc_x);
	assign item_flags.box_valid = (row_inc >= wr_x) && (col_inc >= wc_x);
	assign item_flags.frame_end = last_col && last_row;

	assign item_row_sum = row_sum_q + ROW_SUM_W'(pixel);

	assign addr_w = {slot_q, col_q};
	assign addr_a = {slot_prev, col_q};
	assign addr_b = {slot_top, col_q};
	assign addr_c = {slot_q, col_left};
	assign addr_d = {slot_top, col_left};

	assign pixel_ready = !q_full;
	assign q_push      = pixel_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			slot_q    <= '0;
			row_sum_q <= '0;
		end else if (q_push) begin
			if (last_col) begin
				col_q     <= '0;
				row_sum_q <= '0;
				if (last_row) begin
					row_q  <= '0;
					slot_q <= '0;
				end else begin
					row_q  <= row_q + ROW_W'(1);
					slot_q <= (slot_q == SLOT_W'(LINES - 1)) ? '0 : slot_q + SLOT_W'(1);
				end
			end else begin
				col_q     <= col_q + COL_W'(1);
				row_sum_q <= item_row_sum;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/iibs_queue.sv =====
`default_nettype none

module iibs_queue
	import iibs_pkg::*;
#(
	parameter int DATA_W = 96,
	parameter int DEPTH  = 4,
	parameter int PTR_W  = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output logic [DATA_W-1:0] head_data
);

	logic [DATA_W-1:0] entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]    count_q;

	assign full       = (count_q == (PTR_W + 1)'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (PTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (PTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/iibs_line_store.sv =====
`default_nettype none

module iibs_line_store
	import iibs_pkg::*;
#(
	parameter int ADDR_W = 17,
	parameter int DEPTH  = 66560
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [SUM_W-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr0,
	input  logic [ADDR_W-1:0] rd_addr1,
	output logic [SUM_W-1:0]  rd_data0,
	output logic [SUM_W-1:0]  rd_data1
);

	logic [SUM_W-1:0] mem [DEPTH];

	// read returns the old word when the same address is written in that cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data0 <= mem[rd_addr0];
			rd_data1 <= mem[rd_addr1];
		end
	end

endmodule

`default_nettype wire

// ===== src/iibs_back.sv =====
`default_nettype none

module iibs_back
	import iibs_pkg::*;
#(
	parameter int ADDR_W    = 17,
	parameter int MEM_DEPTH = 66560
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_pop,
	input  iibs_flags_t            q_flags,
	input  logic [ROW_SUM_W-1:0]   q_row_sum,
	input  logic [ADDR_W-1:0]      q_addr_w,
	input  logic [ADDR_W-1:0]      q_addr_a,
	input  logic [ADDR_W-1:0]      q_addr_b,
	input  logic [ADDR_W-1:0]      q_addr_c,
	input  logic [ADDR_W-1:0]      q_addr_d,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast
);

	logic                 v_s2;
	iibs_flags_t          flags_s2;
	logic [ROW_SUM_W-1:0] row_sum_s2;
	logic [ADDR_W-1:0]    addr_w_s2;
	logic                 fwd_a_s2, fwd_b_s2, fwd_c_s2, fwd_d_s2;
	logic [SUM_W-1:0]     fwd_val_s2;
	logic [SUM_W-1:0]     rd_a, rd_b, rd_c, rd_d;
	logic [SUM_W-1:0]     a_eff, b_eff, c_eff, d_eff, here_s2, corr_s2;

	logic             v_s3;
	logic [SUM_W-1:0] here_s3, corr_s3, sum_s3;
	logic             valid_s3, fend_s3;

	logic             out_v_q;
	logic [SUM_W-1:0] out_sum_q;
	logic             out_valid_q, out_fend_q;

	logic out_ready, s3_ready, s3_adv, s2_ready, s2_adv;

	assign out_ready = !out_v_q || m_tready;
	assign s3_adv    = v_s3 && out_ready;
	assign s3_ready  = !v_s3 || out_ready;
	assign s2_adv    = v_s2 && s3_ready;
	assign s2_ready  = !v_s2 || s3_ready;
	assign q_pop     = q_valid && s2_ready;

	// copy 0 serves the column above, copy 1 the column left of the box
	iibs_line_store #(.ADDR_W(ADDR_W), .DEPTH(MEM_DEPTH)) u_store_up (
		.clk      (clk),
		.wr_en    (s2_adv),
		.wr_addr  (addr_w_s2),
		.wr_data  (here_s2),
		.rd_en    (q_pop),
		.rd_addr0 (q_addr_a),
		.rd_addr1 (q_addr_b),
		.rd_data0 (rd_a),
		.rd_data1 (rd_b)
	);

	iibs_line_store #(.ADDR_W(ADDR_W), .DEPTH(MEM_DEPTH)) u_store_left (
		.clk      (clk),
		.wr_en    (s2_adv),
		.wr_addr  (addr_w_s2),
		.wr_data  (here_s2),
		.rd_en    (q_pop),
		.rd_addr0 (q_addr_c),
		.rd_addr1 (q_addr_d),
		.rd_data0 (rd_c),
		.rd_data1 (rd_d)
	);

	assign a_eff = flags_s2.a_zero ? '0 : (fwd_a_s2 ? fwd_val_s2 : rd_a);
	assign b_eff = flags_s2.top_zero ? '0 : (fwd_b_s2 ? fwd_val_s2 : rd_b);
	assign c_eff = flags_s2.left_zero ? '0 : (fwd_c_s2 ? fwd_val_s2 : rd_c);
	assign d_eff = (flags_s2.top_zero || flags_s2.left_zero) ? '0
		: (fwd_d_s2 ? fwd_val_s2 : rd_d);

	assign here_s2 = SUM_W'(row_sum_s2) + a_eff;
	assign corr_s2 = d_eff - b_eff - c_eff;

	assign sum_s3 = valid_s3 ? here_s3 + corr_s3 : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (q_pop) begin
				v_s2 <= 1'b1;
			end else if (s2_adv) begin
				v_s2 <= 1'b0;
			end
			if (s2_adv) begin
				v_s3 <= 1'b1;
			end else if (s3_adv) begin
				v_s3 <= 1'b0;
			end
			if (s3_adv) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// the word in stage 2 writes on the same edge as this read, so take its sum directly
	always_ff @(posedge clk) begin
		if (q_pop) begin
			flags_s2   <= q_flags;
			row_sum_s2 <= q_row_sum;
			addr_w_s2  <= q_addr_w;
			fwd_a_s2   <= v_s2 && (q_addr_a == addr_w_s2);
			fwd_b_s2   <= v_s2 && (q_addr_b == addr_w_s2);
			fwd_c_s2   <= v_s2 && (q_addr_c == addr_w_s2);
			fwd_d_s2   <= v_s2 && (q_addr_d == addr_w_s2);
			fwd_val_s2 <= here_s2;
		end
		if (s2_adv) begin
			here_s3  <= here_s2;
			corr_s3  <= corr_s2;
			valid_s3 <= flags_s2.box_valid;
			fend_s3  <= flags_s2.frame_end;
		end
		if (s3_adv) begin
			out_sum_q   <= sum_s3;
			out_valid_q <= valid_s3;
			out_fend_q  <= fend_s3;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = OUT_TDATA_W'(out_sum_q);
	assign m_tuser  = out_valid_q;
	assign m_tlast  = out_fend_q;

endmodule

`default_nettype wire

// ===== src/iibs_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module iibs_checker
	import iibs_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser,
	input logic                   m_tlast
);

	logic [3:0] pending_q;
	logic       in_acc, out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	// words taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   pending_q <= pending_q + 4'd1;
				2'b01:   pending_q <= pending_q - 4'd1;
				default: pending_q <= pending_q;
			endcase
		end
	end

	`IIBS_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result word changed while stalled")
	`IIBS_ASSERT_IMPL(a_invalid_zero, clk, arst_n, m_tvalid && !m_tuser, m_tdata == '0, "invalid box carries a non-zero sum")
	`IIBS_ASSERT_IMPL(a_no_spurious, clk, arst_n, m_tvalid, pending_q != 4'd0, "result word with no pixel outstanding")
	`IIBS_ASSERT_IMPL(a_bounded, clk, arst_n, s_tready, pending_q < 4'd7, "more pixels in flight than the pipeline holds")

endmodule

bind integral_image_box_sum_core iibs_checker u_iibs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

`default_nettype wire

// ===== sim/integral_image_box_sum_core_tb.sv =====
`timescale 1ns / 100ps

module integral_image_box_sum_core_tb;
	import iibs_pkg::*;

	localparam int LINE_COLS      = 1024;
	localparam int LINE_SLOTS     = 65;
	localparam int BOX_ROWS_MAX   = 64;
	localparam int FRAME_ROWS_MAX = 1024;
	localparam int BOX_COLS_MAX   = (1 << CFG_DATA_W) - 1;
	localparam int RANDOM_PIXELS  = 1040;
	localparam int RUN_LIMIT      = 1000000;
	localparam int REPORT_LIMIT   = 10;
	localparam int HOLD_AFTER     = 600;
	localparam int HOLD_CYCLES    = 300;
	localparam logic [CFG_INDEX_W-1:0] REG_NONE = 8'hFF;

	typedef enum logic {STEP_WRITE, STEP_PIXEL} step_kind_t;
	typedef enum int {PIX_ANY, PIX_FULL, PIX_BINARY, PIX_DIM, PIX_BLACK} pix_style_t;

	typedef struct packed {
		step_kind_t             kind;
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0]  value;
		logic                   typed;
		logic [SUM_W-1:0]       exp_sum;
		logic                   exp_valid;
		logic                   exp_fend;
	} stim_row_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic             valid;
		logic             fend;
	} box_word_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata   = '0;  // pixel
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;         // box_sum
	logic                   m_tuser;         // box_valid
	logic                   m_tlast;         // frame_end

	integral_image_box_sum_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// summed-area predictor state
	logic [CFG_DATA_W-1:0] img_w_reg = IMAGE_WIDTH_RESET;
	logic [CFG_DATA_W-1:0] img_h_reg = IMAGE_HEIGHT_RESET;
	logic [WIN_ROWS_W-1:0] win_r_reg = WINDOW_ROWS_RESET;
	logic [CFG_DATA_W-1:0] win_c_reg = WINDOW_COLS_RESET;
	bit [SUM_W-1:0]        sat_lines [LINE_SLOTS*LINE_COLS];
	bit [ROW_SUM_W-1:0]    row_acc = '0;
	int                    col_pos = 0;
	int                    row_pos = 0;
	box_word_t             box_queue [$];

	int  cycle_count  = 0;
	int  results_seen = 0;
	int  frames_seen  = 0;
	int  fault_count  = 0;
	int  pixels_sent  = 0;
	int  reg_writes   = 0;
	bit  calm         = 1'b0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int clamp_cfg(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	// rows above the frame or columns left of it read as zero
	function automatic bit [SUM_W-1:0] sat_at(int r, int c);
		if (r < 0 || c < 0) return '0;
		return sat_lines[(r % LINE_SLOTS) * LINE_COLS + c];
	endfunction

	function automatic box_word_t box_step(logic [7:0] pix);
		int             w, h, wr, wc;
		bit [SUM_W-1:0] here;
		box_word_t      res;
		w  = clamp_cfg(int'(img_w_reg), LINE_COLS);
		h  = clamp_cfg(int'(img_h_reg), FRAME_ROWS_MAX);
		wr = clamp_cfg(int'(win_r_reg), BOX_ROWS_MAX);
		wc = clamp_cfg(int'(win_c_reg), BOX_COLS_MAX);
		res = '0;
		row_acc = row_acc + ROW_SUM_W'(pix);
		here = SUM_W'(row_acc) + sat_at(row_pos - 1, col_pos);
		sat_lines[(row_pos % LINE_SLOTS) * LINE_COLS + col_pos] = here;
		if (row_pos >= wr - 1 && col_pos >= wc - 1) begin
			res.valid = 1'b1;
			res.sum = here - sat_at(row_pos - wr, col_pos) - sat_at(row_pos, col_pos - wc)
				+ sat_at(row_pos - wr, col_pos - wc);
		end
		if (col_pos + 1 >= w) begin
			row_acc = '0;
			col_pos = 0;
			if (row_pos + 1 >= h) begin
				res.fend = 1'b1;
				row_pos = 0;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
		return res;
	endfunction

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic pix_style_t pick_style();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return PIX_ANY;
		return pix_style_t'(r - 5);
	endfunction

	function automatic logic [7:0] pick_pixel(pix_style_t style);
		case (style)
			PIX_FULL:   return 8'hFF;
			PIX_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			PIX_DIM:    return 8'($urandom_range(0, 3));
			PIX_BLACK:  return 8'h00;
			default:    return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic stim_row_t wr_row(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		stim_row_t row;
		row = '0;
		row.kind = STEP_WRITE;
		row.idx = idx;
		row.value = value;
		return row;
	endfunction

	function automatic stim_row_t px_row(logic [7:0] pix);
		stim_row_t row;
		row = '0;
		row.kind = STEP_PIXEL;
		row.value = CFG_DATA_W'(pix);
		return row;
	endfunction

	function automatic stim_row_t chk_row(logic [7:0] pix, logic [SUM_W-1:0] sum, logic valid,
			logic fend);
		stim_row_t row;
		row = px_row(pix);
		row.typed = 1'b1;
		row.exp_sum = sum;
		row.exp_valid = valid;
		row.exp_fend = fend;
		return row;
	endfunction

	task automatic send_pixel(input logic [7:0] pix, input logic typed, input box_word_t typed_word);
		box_word_t pred;
		int        gap;
		cfg_valid <= 1'b0;
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		do @(posedge clk); while (!s_tready);
		pred = box_step(pix);
		box_queue.push_back(typed ? typed_word : pred);
		pixels_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// registers change only with the pipe drained
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		s_tvalid <= 1'b0;
		while (box_queue.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_IMAGE_WIDTH:  img_w_reg = value;
			REG_IMAGE_HEIGHT: img_h_reg = value;
			REG_WINDOW_ROWS:  win_r_reg = value[WIN_ROWS_W-1:0];
			REG_WINDOW_COLS:  win_c_reg = value;
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic run_setting(input logic [CFG_DATA_W-1:0] w, h, wr, wc, input int frames);
		int per_frame;
		pix_style_t style;
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_WINDOW_ROWS, wr);
		write_reg(REG_WINDOW_COLS, wc);
		per_frame = clamp_cfg(int'(w), LINE_COLS) * clamp_cfg(int'(h), FRAME_ROWS_MAX);
		repeat (frames) begin
			style = pick_style();
			repeat (per_frame) send_pixel(pick_pixel(style), 1'b0, '0);
		end
	endtask

	task automatic report_fault(input string what);
		fault_count++;
		if (fault_count <= REPORT_LIMIT) $display("%0t: %s", $time, what);
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 400 == 0) calm <= ($urandom_range(0, 3) == 0);
		if (cycle_count >= RUN_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still expected", cycle_count,
				box_queue.size());
			$display("** integral_image_box_sum_core: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		box_word_t exp_word;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen <= results_seen + 1;
			if (m_tlast) frames_seen <= frames_seen + 1;
			if (box_queue.size() == 0) begin
				report_fault($sformatf("unexpected word sum %0d valid %0b fend %0b",
					m_tdata, m_tuser, m_tlast));
			end else begin
				exp_word = box_queue.pop_front();
				if (m_tdata !== {{(OUT_TDATA_W-SUM_W){1'b0}}, exp_word.sum} ||
						m_tuser !== exp_word.valid || m_tlast !== exp_word.fend)
					report_fault($sformatf(
						"sum exp %0d got %0d, valid exp %0b got %0b, fend exp %0b got %0b",
						exp_word.sum, m_tdata, exp_word.valid, m_tuser, exp_word.fend, m_tlast));
			end
		end
	end

	// receiver side with one long hold-off to back the pipe up into the input
	initial begin : rx_side
		int stall_left = 0;
		int hold_left  = 0;
		bit hold_done  = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (!hold_done && results_seen >= HOLD_AFTER && s_tvalid) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = pick_gap();
				m_tready <= (stall_left == 0);
				if (stall_left > 0) stall_left--;
			end
		end
	end

	initial begin : stimulus
		stim_row_t             directed_rows [$];
		stim_row_t             row;
		int                    start_count, r, frames, per, left;
		logic [CFG_DATA_W-1:0] w, h, wr, wc;
		bit                    deep;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		directed_rows = {
			// reset setting is a 1x1 box, so each sum is the pixel itself
			chk_row(8'h00, 28'd0, 1'b1, 1'b0),
			chk_row(8'hFF, 28'd255, 1'b1, 1'b0),
			chk_row(8'h01, 28'd1, 1'b1, 1'b0),
			chk_row(8'h80, 28'd128, 1'b1, 1'b0),
			chk_row(8'hAA, 28'd170, 1'b1, 1'b0),
			chk_row(8'h55, 28'd85, 1'b1, 1'b0),
			// shrink the frame mid-row: the next pixel closes row 0
			wr_row(REG_IMAGE_WIDTH, 11'd7),
			wr_row(REG_IMAGE_HEIGHT, 11'd2),
			wr_row(REG_WINDOW_ROWS, 11'd2),
			wr_row(REG_WINDOW_COLS, 11'd3),
			px_row(8'hFF), px_row(8'h10), px_row(8'hFF), px_row(8'h00),
			px_row(8'h7F), px_row(8'hFF), px_row(8'hFE), px_row(8'h01),
			// zero sizes act as one, giving single-pixel frames
			wr_row(REG_IMAGE_WIDTH, 11'd0),
			wr_row(REG_IMAGE_HEIGHT, 11'd0),
			wr_row(REG_WINDOW_ROWS, 11'd0),
			wr_row(REG_WINDOW_COLS, 11'd0),
			wr_row(REG_NONE, 11'h7FF),
			chk_row(8'hFF, 28'd255, 1'b1, 1'b1),
			chk_row(8'h3C, 28'd60, 1'b1, 1'b1),
			// box taller than the frame never completes
			wr_row(REG_IMAGE_WIDTH, 11'd2),
			wr_row(REG_IMAGE_HEIGHT, 11'd2),
			wr_row(REG_WINDOW_ROWS, 11'd127),
			wr_row(REG_WINDOW_COLS, 11'd2),
			chk_row(8'hFF, 28'd0, 1'b0, 1'b0),
			chk_row(8'h00, 28'd0, 1'b0, 1'b0),
			chk_row(8'h80, 28'd0, 1'b0, 1'b0),
			chk_row(8'h01, 28'd0, 1'b0, 1'b1),
			// box wider than the frame
			wr_row(REG_IMAGE_HEIGHT, 11'd1),
			wr_row(REG_WINDOW_ROWS, 11'd1),
			wr_row(REG_WINDOW_COLS, 11'd2047),
			chk_row(8'hFF, 28'd0, 1'b0, 1'b0),
			chk_row(8'hFF, 28'd0, 1'b0, 1'b1)
		};

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == STEP_WRITE)
				write_reg(row.idx, row.value);
			else
				send_pixel(row.value[7:0], row.typed, {row.exp_sum, row.exp_valid, row.exp_fend});
		end

		start_count = pixels_sent;
		while (pixels_sent - start_count < RANDOM_PIXELS) begin
			r = $urandom_range(0, 9);
			if (r < 6)
				w = 11'($urandom_range(1, 12));
			else if (r < 9)
				w = 11'($urandom_range(13, 48));
			else
				w = 11'($urandom_range(49, 100));
			h = 11'($urandom_range(1, 8));
			frames = $urandom_range(1, 3);
			// tall narrow frames wrap the line store with the deepest boxes
			deep = ($urandom_range(0, 5) == 0);
			if (deep) begin
				w = 11'($urandom_range(1, 3));
				h = 11'($urandom_range(60, 80));
				frames = 1;
				wr = $urandom_range(0, 1) ? 11'd64 : 11'($urandom_range(50, 64));
			end else begin
				wr = 11'($urandom_range(1, int'(h)));
			end
			if ($urandom_range(0, 7) == 0) wr = 11'($urandom_range(0, 127));
			// upper data bits fall outside the row register
			wr = wr | 11'($urandom_range(0, 15) << WIN_ROWS_W);
			r = $urandom_range(0, 9);
			if (r == 0)
				wc = 11'($urandom_range(0, int'(w) + 3));
			else if (r == 1)
				wc = 11'($urandom_range(0, 2047));
			else
				wc = 11'($urandom_range(1, int'(w)));
			if ($urandom_range(0, 15) == 0) w = 11'd0;
			if ($urandom_range(0, 15) == 0) h = 11'd0;
			// keep the last setting close to the pixel budget
			left = RANDOM_PIXELS - (pixels_sent - start_count);
			per = clamp_cfg(int'(w), LINE_COLS) * clamp_cfg(int'(h), FRAME_ROWS_MAX);
			if (per * frames > left) frames = 1;
			if (per > left) h = 11'(left / clamp_cfg(int'(w), LINE_COLS) + 1);
			run_setting(w, h, wr, wc, frames);
		end

		s_tvalid <= 1'b0;
		cfg_valid <= 1'b0;
		while (box_queue.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("ran %0d pixel words into %0d box words over %0d frames, %0d register writes",
			pixels_sent, results_seen, frames_seen, reg_writes);
		$display("frames from one pixel up to 100 wide or 80 tall, boxes up to 64 rows,"
			, " %0d mismatches", fault_count);
		if (fault_count == 0)
			$display("** integral_image_box_sum_core: PASSED **");
		else
			$display("** integral_image_box_sum_core: FAILED **");
		$finish;
	end

endmodule

// ===== integral_image_box_sum_core.f =====
+incdir+src
src/iibs_pkg.sv
src/iibs_front.sv
src/iibs_queue.sv
src/iibs_line_store.sv
src/iibs_back.sv
src/integral_image_box_sum_core.sv
src/iibs_checker.sv
sim/integral_image_box_sum_core_tb.sv
